### sv/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// shared widths, codes and defaults of the bitmap page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int LIMIT_W   = 14;
   localparam int COUNT_W   = 14;
   localparam int ADDR_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int OPCODE_W  = 2;
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   localparam int DEF_MAX_PAGES  = 8192;
   localparam int DEF_PAGE_BYTES = 4096;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8192);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MARK  = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_OOM          = 3'd1,
      ST_INVALID      = 3'd2,
      ST_ALREADY_FREE = 3'd3,
      ST_ALREADY_USED = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } first_type;

   // lowest set bit of a word
   function automatic first_type first_one(input logic [WORD_BITS-1:0] vec);
      first_type res;
      res.found = 1'b0;
      res.pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res.found = 1'b1;
            res.pos   = BIT_W'(i);
         end
      end
      return res;
   endfunction

endpackage

### sv/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// first-fit page frame allocator over a used/free bitmap held in a memory
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  req     | in        | req_valid/req_stall  | opcode, page address
//  rsp     | out       | rsp_valid/rsp_stall  | status, address, free flag, count
//  csr     | in        | csr_valid/csr_ready  | page limit
//
//  free, mark and query pass through S_READ, S_CHECK and S_RESP, an invalid
//  page goes straight to S_RESP; allocate repeats S_READ and S_CHECK for each
//  bitmap word scanned, with one bitmap memory port and one word compare per read
//  after reset a clearing pass over every bitmap word sets every frame used
//  one request at a time; a result register holds a stalled beat so the next
//  request goes in, and a second finished request waits until the beat is taken
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
   parameter int MAX_PAGES  = bpfa_pkg::DEF_MAX_PAGES,
   parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bpfa_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [bpfa_pkg::ADDR_W-1:0]    req_page_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bpfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bpfa_pkg::ADDR_W-1:0]    rsp_allocated_address,
   output logic                           rsp_page_is_free,
   output logic [bpfa_pkg::COUNT_W-1:0]   rsp_free_pages,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpfa_pkg::LIMIT_W-1:0]   csr_page_limit
);
   import bpfa_pkg::*;

   localparam int WORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORDS);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CMP_W      = (WORD_AW + BIT_W + 1 > LIMIT_W + 1) ?
                               WORD_AW + BIT_W + 1 : LIMIT_W + 1;
   localparam int MAX_EFF    = (MAX_PAGES > (1 << LIMIT_W) - 1) ?
                               (1 << LIMIT_W) - 1 : MAX_PAGES;

   logic [WORD_BITS-1:0] mem [WORDS];

   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   opcode_type           op_ff, op_in;
   logic [WORD_BITS-1:0] rd_ff;
   status_type           status_ff, status_in;
   logic [ADDR_W-1:0]    alloc_ff, alloc_in;
   logic                 isfree_ff, isfree_in;
   logic                 out_valid_ff, out_valid_in;
   status_type           out_status_ff;
   logic [ADDR_W-1:0]    out_alloc_ff;
   logic                 out_isfree_ff;
   logic [COUNT_W-1:0]   out_count_ff;

   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 out_load;
   logic [LIMIT_W-1:0]   lim_eff;
   logic [ADDR_W-1:0]    req_idx;
   logic [CMP_W-1:0]     req_word_wide;
   logic [CMP_W-1:0]     base;
   logic [CMP_W-1:0]     rem;
   logic [CMP_W-1:0]     alloc_idx;
   logic                 last_word;
   logic [WORD_BITS-1:0] valid_mask;
   first_type            first;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_allocated_address = out_alloc_ff;
   assign rsp_page_is_free      = out_isfree_ff;
   assign rsp_free_pages        = out_count_ff;

   assign lim_eff = (limit_ff > LIMIT_W'(MAX_EFF)) ? LIMIT_W'(MAX_EFF) : limit_ff;
   assign req_idx = req_page_address >> PAGE_SHIFT;
   assign req_word_wide = CMP_W'(req_idx[LIMIT_W-1:0]) >> BIT_W;

   assign base       = CMP_W'(word_ff) << BIT_W;
   assign rem        = CMP_W'(lim_eff) - base;
   assign last_word  = (base + CMP_W'(WORD_BITS)) >= CMP_W'(lim_eff);
   assign valid_mask = (rem >= CMP_W'(WORD_BITS)) ? '1 :
                       ((WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1));
   assign first      = first_one(~rd_ff & valid_mask);
   assign alloc_idx  = base | CMP_W'(first.pos);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      alloc_in     = alloc_ff;
      isfree_in    = isfree_ff;
      mem_we       = 1'b0;
      mem_wdata    = '1;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff & rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            word_in = word_ff + WORD_AW'(1);
            if (word_ff == WORD_AW'(WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = opcode_type'(req_opcode);
               bit_in    = req_idx[BIT_W-1:0];
               status_in = ST_OK;
               alloc_in  = '0;
               isfree_in = 1'b0;
               if (opcode_type'(req_opcode) == OP_ALLOC) begin
                  word_in = '0;
                  if (lim_eff == '0) begin
                     status_in = ST_OOM;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_READ;
                  end
               end else if (req_idx >= ADDR_W'(lim_eff)) begin
                  status_in = ST_INVALID;
                  state_in  = S_RESP;
               end else begin
                  word_in  = req_word_wide[WORD_AW-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_RESP;
            case (op_ff)
               OP_ALLOC: begin
                  if (first.found) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_ff | (WORD_BITS'(1) << first.pos);
                     alloc_in  = ADDR_W'(alloc_idx) << PAGE_SHIFT;
                     if (count_ff != '0) count_in = count_ff - COUNT_W'(1);
                  end else if (last_word) begin
                     status_in = ST_OOM;
                  end else begin
                     word_in  = word_ff + WORD_AW'(1);
                     state_in = S_READ;
                  end
               end
               OP_FREE: begin
                  if (!rd_ff[bit_ff]) begin
                     status_in = ST_ALREADY_FREE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_ff & ~(WORD_BITS'(1) << bit_ff);
                     if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
                  end
               end
               OP_MARK: begin
                  if (rd_ff[bit_ff]) begin
                     status_in = ST_ALREADY_USED;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_ff | (WORD_BITS'(1) << bit_ff);
                     if (count_ff != '0) count_in = count_ff - COUNT_W'(1);
                  end
               end
               default: begin
                  isfree_in = ~rd_ff[bit_ff];
               end
            endcase
         end
         S_RESP: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         word_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         word_ff      <= word_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) limit_ff <= csr_page_limit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff    <= bit_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      alloc_ff  <= alloc_in;
      isfree_ff <= isfree_in;
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= status_ff;
         out_alloc_ff  <= alloc_ff;
         out_isfree_ff <= isfree_ff;
         out_count_ff  <= count_ff;
      end
   end

   // bitmap memory, one port
   always_ff @(posedge clock) begin
      if (mem_we) mem[word_ff] <= mem_wdata;
      rd_ff <= mem[word_ff];
   end

endmodule
